FILE: src/cc_pkg.sv
// ----------------------------------------------------------------------------
// cc_pkg: shared types, constants and helpers
// Queue entry layout, divider request/response, LFSR and jitter helpers for
// the circle contact block.
// ----------------------------------------------------------------------------
`default_nettype none

package cc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0] LFSR_SEED   = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] LIMIT_RESET = 16'd1;
  localparam int          JITTER_MAX  = 3277;
  localparam int          JITTER_SPAN = 6555;
  localparam logic [14:0] NORM_MAX    = 15'h7FFF;
  localparam logic [31:0] SHIFT_MAX   = 32'h7FFF_FFFF;

  // classified pair, handed from the front to the back
  typedef struct packed {
    logic        touching;
    logic [30:0] ux;
    logic [30:0] uy;
    logic        negx;
    logic        negy;
    logic [62:0] sum;
    logic [30:0] rsum;
    logic [31:0] ima;
    logic [31:0] imb;
    logic [15:0] bounce;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic        long_div;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [11:0] mag;
    logic        neg;
  } jit_t;

  function automatic logic [15:0] lfsr_step(logic [15:0] l);
    logic [15:0] r;
    r = {1'b0, l[15:1]};
    if (l[0]) r = r ^ LFSR_TAPS;
    return r;
  endfunction

  function automatic jit_t jitter_of(logic [15:0] l);
    logic [28:0] p;
    logic [12:0] j;
    jit_t        r;
    p = 29'(l) * 29'(JITTER_SPAN);
    j = p[28:16];
    if (j >= 13'(JITTER_MAX)) begin
      r.mag = 12'(j - 13'(JITTER_MAX));
      r.neg = 1'b0;
    end else begin
      r.mag = 12'(13'(JITTER_MAX) - j);
      r.neg = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/cc_ifs.sv
// ----------------------------------------------------------------------------
// cc_ifs: channel interfaces
// Pair channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface cc_pair_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_a_x;
  logic signed [COORD_WIDTH-1:0] pos_a_y;
  logic signed [COORD_WIDTH-1:0] pos_b_x;
  logic signed [COORD_WIDTH-1:0] pos_b_y;
  logic        [29:0]            radius_a;
  logic        [29:0]            radius_b;
  logic        [15:0]            bounce_a;
  logic        [15:0]            bounce_b;
  logic                          dynamic_a;
  logic                          dynamic_b;
  logic        [31:0]            inv_mass_a;
  logic        [31:0]            inv_mass_b;

  modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, radius_a, radius_b,
                  bounce_a, bounce_b, dynamic_a, dynamic_b, inv_mass_a, inv_mass_b,
                  input ready);
  modport sink (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, radius_a, radius_b,
                bounce_a, bounce_b, dynamic_a, dynamic_b, inv_mass_a, inv_mass_b,
                output ready);
endinterface

interface cc_result_if;
  logic               valid;
  logic               ready;
  logic               touching;
  logic        [30:0] depth;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic        [15:0] mean_bounce;
  logic signed [31:0] shift_a_x;
  logic signed [31:0] shift_a_y;
  logic signed [31:0] shift_b_x;
  logic signed [31:0] shift_b_y;

  modport source (output valid, touching, depth, normal_x, normal_y, mean_bounce,
                  shift_a_x, shift_a_y, shift_b_x, shift_b_y, input ready);
  modport sink (input valid, touching, depth, normal_x, normal_y, mean_bounce,
                shift_a_x, shift_a_y, shift_b_x, shift_b_y, output ready);
endinterface

`default_nettype wire

FILE: src/circle_contact_and_separation.sv
// ----------------------------------------------------------------------------
// circle_contact_and_separation: circle pair contact and separation
// Contact test, depth, unit normal, mean restitution and mass-weighted
// position shifts for one pair of circles, Q16.16 fixed point.
//
//   channel  dir  handshake            carries
//   req      in   req.valid/req.ready  positions, radii, restitutions, flags,
//                                      inverse masses
//   rsp      out  rsp.valid/rsp.ready  touching, depth, normal, mean bounce,
//                                      shifts
//   cfg      in   cfg_we               degenerate_limit
//
// The front takes no new pair until it has pushed the last one to the queue,
// waiting while the queue is full. A pair with no contact skips the square
// root and the divider; a contact goes through the 32-step square root and
// four passes through the shared restoring divider (17, 17, 32, 32 steps).
// With zero total inverse mass the mass passes are skipped. The queue and the
// result register let either side stall without losing a transfer.
// Reset is synchronous; it clears control state and the result valid flag and
// reloads the LFSR and the degenerate limit.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contact_and_separation #(
  parameter int COORD_WIDTH = cc_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  cc_pair_if.sink          req,
  cc_result_if.source      rsp,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);
  import cc_pkg::*;

  entry_t   push_entry, head;
  logic     push, full, pop, not_empty;
  div_req_t dreq;
  div_rsp_t drsp;

  cc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .req(req), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push_entry(push_entry), .push(push), .full(full)
  );

  cc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .full(full),
    .pop(pop), .head(head), .not_empty(not_empty)
  );

  cc_div u_div (.clk(clk), .rst(rst), .dreq(dreq), .drsp(drsp));

  cc_back u_back (
    .clk(clk), .rst(rst), .head(head), .not_empty(not_empty), .pop(pop),
    .dreq(dreq), .drsp(drsp), .rsp(rsp)
  );

endmodule

`default_nettype wire

FILE: src/cc_front.sv
// ----------------------------------------------------------------------------
// cc_front: pair intake and classification
// Takes a pair, forms the centre difference and squared distance, decides on
// contact, jitters the direction of a contact within the degenerate limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  cc_pair_if.sink            req,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  output cc_pkg::entry_t     push_entry,
  output logic               push,
  input  wire logic          full
);
  import cc_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_MUL  = 3'd2;
  localparam logic [2:0] F_CLS  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]  state;
  logic [15:0] limit;
  logic [15:0] lfsr;

  logic signed [COORD_WIDTH-1:0] pax, pay, pbx, pby;
  logic [29:0] ra, rb;
  logic [15:0] ba, bb;
  logic        dyn;
  logic [31:0] ima, imb;

  logic [30:0] ux, uy;
  logic        negx, negy, far;
  logic [30:0] rsum;
  logic [61:0] sqx, sqy, rsq;
  entry_t      ent;

  logic signed [COORD_WIDTH:0] dx, dy;
  logic [COORD_WIDTH:0]        ax, ay;
  logic [63:0]                 ax64, ay64;
  logic [62:0]                 sum;
  logic                        contact, degen;
  logic [15:0]                 l1, l2;
  jit_t                        jx, jy;
  logic [24:0]                 jsum;

  assign req.ready  = (state == F_IDLE);
  assign push       = (state == F_PUSH) && !full;
  assign push_entry = ent;

  // centre difference and magnitudes
  always_comb begin
    dx   = {pax[COORD_WIDTH-1], pax} - {pbx[COORD_WIDTH-1], pbx};
    dy   = {pay[COORD_WIDTH-1], pay} - {pby[COORD_WIDTH-1], pby};
    ax   = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dx) : (COORD_WIDTH+1)'(dx);
    ay   = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : (COORD_WIDTH+1)'(dy);
    ax64 = 64'(ax);
    ay64 = 64'(ay);
  end

  // contact test and jitter direction
  always_comb begin
    sum     = 63'(sqx) + 63'(sqy);
    contact = dyn && !far && (sum <= 63'(rsq));
    degen   = sum <= 63'({limit, 16'h0000});
    l1      = lfsr_step(lfsr);
    l2      = lfsr_step(l1);
    jx      = jitter_of(l1);
    jy      = jitter_of(l2);
    if (jx.mag == 12'd0 && jy.mag == 12'd0) begin
      jx.mag = 12'(JITTER_MAX);
      jx.neg = 1'b0;
    end
    jsum = 25'(24'(jx.mag) * 24'(jx.mag)) + 25'(24'(jy.mag) * 24'(jy.mag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      limit <= LIMIT_RESET;
      lfsr  <= LFSR_SEED;
    end else begin
      if (cfg_we) limit <= cfg_data;
      case (state)
        F_IDLE: begin
          if (req.valid) begin
            pax   <= req.pos_a_x;
            pay   <= req.pos_a_y;
            pbx   <= req.pos_b_x;
            pby   <= req.pos_b_y;
            ra    <= req.radius_a;
            rb    <= req.radius_b;
            ba    <= req.bounce_a;
            bb    <= req.bounce_b;
            dyn   <= req.dynamic_a | req.dynamic_b;
            ima   <= req.inv_mass_a;
            imb   <= req.inv_mass_b;
            state <= F_SQ;
          end
        end
        F_SQ: begin
          ux    <= ax64[30:0];
          uy    <= ay64[30:0];
          negx  <= dx[COORD_WIDTH];
          negy  <= dy[COORD_WIDTH];
          far   <= (|ax64[63:31]) || (|ay64[63:31]);
          rsum  <= 31'(ra) + 31'(rb);
          state <= F_MUL;
        end
        F_MUL: begin
          sqx   <= 62'(ux) * 62'(ux);
          sqy   <= 62'(uy) * 62'(uy);
          rsq   <= 62'(rsum) * 62'(rsum);
          state <= F_CLS;
        end
        F_CLS: begin
          ent.touching <= contact;
          ent.rsum     <= rsum;
          ent.ima      <= ima;
          ent.imb      <= imb;
          ent.bounce   <= 16'((17'(ba) + 17'(bb)) >> 1);
          if (contact && degen) begin
            ent.ux   <= 31'(jx.mag);
            ent.uy   <= 31'(jy.mag);
            ent.negx <= jx.neg;
            ent.negy <= jy.neg;
            ent.sum  <= 63'(jsum);
            lfsr     <= l2;
          end else begin
            ent.ux   <= ux;
            ent.uy   <= uy;
            ent.negx <= negx;
            ent.negy <= negy;
            ent.sum  <= sum;
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/cc_queue.sv
// ----------------------------------------------------------------------------
// cc_queue: classified pair queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cc_pkg::entry_t  push_entry,
  output logic                 full,
  input  wire logic            pop,
  output cc_pkg::entry_t       head,
  output logic                 not_empty
);
  import cc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      // store and advance
      if (push) begin
        slots[wr_ptr] <= push_entry;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/cc_div.sv
// ----------------------------------------------------------------------------
// cc_div: shared restoring divider
// One quotient bit per cycle; 17 bits for normals, 32 bits for mass shares.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cc_pkg::div_req_t  dreq,
  output cc_pkg::div_rsp_t       drsp
);
  import cc_pkg::*;

  logic        busy;
  logic        done;
  logic [63:0] rem;
  logic [64:0] dsh;
  logic [31:0] q;
  logic [5:0]  cnt;
  logic        ge;

  assign ge        = {1'b0, rem} >= dsh;
  assign drsp.done = done;
  assign drsp.quot = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        rem  <= dreq.num;
        dsh  <= dreq.long_div ? (65'(dreq.den) << 31) : (65'(dreq.den) << 16);
        cnt  <= dreq.long_div ? 6'd32 : 6'd17;
        q    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // subtract where it fits, shift in the quotient bit
        if (ge) rem <= rem - dsh[63:0];
        q   <= {q[30:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cc_back.sv
// ----------------------------------------------------------------------------
// cc_back: contact resolution
// Square root, depth, normal and mass-weighted shifts for one queued pair,
// then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cc_pkg::entry_t    head,
  input  wire logic              not_empty,
  output logic                   pop,
  output cc_pkg::div_req_t       dreq,
  input  wire cc_pkg::div_rsp_t  drsp,
  cc_result_if.source            rsp
);
  import cc_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SQRT  = 4'd1;
  localparam logic [3:0] B_DEPTH = 4'd2;
  localparam logic [3:0] B_NX_GO = 4'd3;
  localparam logic [3:0] B_NX_WT = 4'd4;
  localparam logic [3:0] B_NY_GO = 4'd5;
  localparam logic [3:0] B_NY_WT = 4'd6;
  localparam logic [3:0] B_MA_GO = 4'd7;
  localparam logic [3:0] B_MA_WT = 4'd8;
  localparam logic [3:0] B_MB_GO = 4'd9;
  localparam logic [3:0] B_MB_WT = 4'd10;
  localparam logic [3:0] B_SHF   = 4'd11;
  localparam logic [3:0] B_OUT   = 4'd12;

  logic [3:0]  state;
  entry_t      e;
  logic [63:0] v, res, sbit;
  logic [31:0] d;
  logic [30:0] depth;
  logic [14:0] nx, ny;
  logic [31:0] ma, mb;
  logic [32:0] total;
  logic [31:0] sax, say, sbx, sby;
  logic [1:0]  scnt;

  logic        o_valid, o_touch;
  logic [30:0] o_depth;
  logic [15:0] o_nx, o_ny, o_mb;
  logic [31:0] o_sax, o_say, o_sbx, o_sby;

  logic [63:0] trial;
  logic [14:0] qn;
  logic [14:0] sn;
  logic [31:0] sm;
  logic        sneg;
  logic [46:0] prod;
  logic [47:0] rnd;
  logic [31:0] smag, sval;
  logic        out_free;

  assign pop      = (state == B_IDLE) && not_empty;
  assign out_free = !o_valid || rsp.ready;
  assign trial    = res + sbit;
  assign qn       = (drsp.quot > 32'(NORM_MAX)) ? NORM_MAX : drsp.quot[14:0];

  // divider operands per phase
  always_comb begin
    dreq = '0;
    case (state)
      B_NX_GO: begin
        dreq.start = 1'b1;
        dreq.num   = {18'd0, e.ux, 15'd0} + 64'(d >> 1);
        dreq.den   = 33'(d);
      end
      B_NY_GO: begin
        dreq.start = 1'b1;
        dreq.num   = {18'd0, e.uy, 15'd0} + 64'(d >> 1);
        dreq.den   = 33'(d);
      end
      B_MA_GO: begin
        dreq.start    = 1'b1;
        dreq.long_div = 1'b1;
        dreq.num      = 64'(63'(depth) * 63'(e.ima)) + 64'(total >> 1);
        dreq.den      = total;
      end
      B_MB_GO: begin
        dreq.start    = 1'b1;
        dreq.long_div = 1'b1;
        dreq.num      = 64'(63'(depth) * 63'(e.imb)) + 64'(total >> 1);
        dreq.den      = total;
      end
      default: dreq = '0;
    endcase
  end

  // one shift component per cycle
  always_comb begin
    case (scnt)
      2'd0:    begin sn = nx; sm = ma; sneg = e.negx;  end
      2'd1:    begin sn = ny; sm = ma; sneg = e.negy;  end
      2'd2:    begin sn = nx; sm = mb; sneg = !e.negx; end
      default: begin sn = ny; sm = mb; sneg = !e.negy; end
    endcase
    prod = 47'(sn) * 47'(sm);
    rnd  = 48'(prod) + 48'd16384;
    smag = (rnd[47:15] > 33'(SHIFT_MAX)) ? SHIFT_MAX : rnd[46:15];
    sval = sneg ? (32'd0 - smag) : smag;
  end

  assign rsp.valid       = o_valid;
  assign rsp.touching    = o_touch;
  assign rsp.depth       = o_depth;
  assign rsp.normal_x    = o_nx;
  assign rsp.normal_y    = o_ny;
  assign rsp.mean_bounce = o_mb;
  assign rsp.shift_a_x   = o_sax;
  assign rsp.shift_a_y   = o_say;
  assign rsp.shift_b_x   = o_sbx;
  assign rsp.shift_b_y   = o_sby;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      o_valid <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one is loaded
      if (o_valid && rsp.ready && state != B_OUT) o_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (not_empty) begin
            e     <= head;
            total <= 33'(head.ima) + 33'(head.imb);
            v     <= 64'(head.sum);
            res   <= '0;
            sbit  <= 64'd1 << 62;
            nx    <= '0;
            ny    <= '0;
            depth <= '0;
            sax   <= '0;
            say   <= '0;
            sbx   <= '0;
            sby   <= '0;
            state <= head.touching ? B_SQRT : B_OUT;
          end
        end
        B_SQRT: begin
          // one result bit per bit pair, one pair a cycle
          if (v >= trial) begin
            v   <= v - trial;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) state <= B_DEPTH;
        end
        B_DEPTH: begin
          d     <= res[31:0];
          depth <= (32'(e.rsum) > res[31:0]) ? 31'(32'(e.rsum) - res[31:0]) : '0;
          state <= B_NX_GO;
        end
        B_NX_GO: state <= B_NX_WT;
        B_NX_WT: begin
          if (drsp.done) begin
            nx    <= qn;
            state <= B_NY_GO;
          end
        end
        B_NY_GO: state <= B_NY_WT;
        B_NY_WT: begin
          if (drsp.done) begin
            ny    <= qn;
            state <= (total == '0) ? B_OUT : B_MA_GO;
          end
        end
        B_MA_GO: state <= B_MA_WT;
        B_MA_WT: begin
          if (drsp.done) begin
            ma    <= drsp.quot;
            state <= B_MB_GO;
          end
        end
        B_MB_GO: state <= B_MB_WT;
        B_MB_WT: begin
          if (drsp.done) begin
            mb    <= drsp.quot;
            scnt  <= 2'd0;
            state <= B_SHF;
          end
        end
        B_SHF: begin
          case (scnt)
            2'd0:    sax <= sval;
            2'd1:    say <= sval;
            2'd2:    sbx <= sval;
            default: sby <= sval;
          endcase
          scnt <= scnt + 2'd1;
          if (scnt == 2'd3) state <= B_OUT;
        end
        B_OUT: begin
          // hold until the result register is free
          if (out_free) begin
            o_valid <= 1'b1;
            o_touch <= e.touching;
            o_depth <= depth;
            o_nx    <= e.negx ? (16'd0 - 16'(nx)) : 16'(nx);
            o_ny    <= e.negy ? (16'd0 - 16'(ny)) : 16'(ny);
            o_mb    <= e.touching ? e.bounce : '0;
            o_sax   <= sax;
            o_say   <= say;
            o_sbx   <= sbx;
            o_sby   <= sby;
            state   <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/cc_checker.sv
// ----------------------------------------------------------------------------
// cc_checker: port-level checks
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module cc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        touching,
  input wire logic [30:0] depth,
  input wire logic [15:0] normal_x,
  input wire logic [15:0] normal_y,
  input wire logic [15:0] mean_bounce,
  input wire logic [31:0] shift_a_x,
  input wire logic [31:0] shift_b_y
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // no result straight out of reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a miss reports zero depth, normal, bounce, shift_a_x and shift_b_y
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !touching |-> depth == 31'd0 && normal_x == 16'd0 &&
      normal_y == 16'd0 && mean_bounce == 16'd0 && shift_a_x == 32'd0 &&
      shift_b_y == 32'd0)
    else $error("non-zero fields on a miss");

  // a contact always carries a direction
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && touching |-> normal_x != 16'd0 || normal_y != 16'd0)
    else $error("contact without normal");

endmodule

bind circle_contact_and_separation cc_checker u_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .touching(rsp.touching), .depth(rsp.depth), .normal_x(rsp.normal_x),
  .normal_y(rsp.normal_y), .mean_bounce(rsp.mean_bounce),
  .shift_a_x(rsp.shift_a_x), .shift_b_y(rsp.shift_b_y)
);

`default_nettype wire

FILE: bench/circle_contact_and_separation_tb.sv
// ----------------------------------------------------------------------------
// circle_contact_and_separation_tb: self-checking bench for circle contact
// Drives circle pairs through the pair channel with random idling and one
// long result hold-off. Every result is compared field by field with a
// contact predictor that keeps its own jitter LFSR and degenerate limit.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contact_and_separation_tb;
  import cc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by;
    logic [29:0] ra, rb;
    logic [15:0] ba, bb;
    logic        da, db;
    logic [31:0] ima, imb;
  } pair_t;

  typedef struct packed {
    logic               touching;
    logic [30:0]        depth;
    logic signed [15:0] nx, ny;
    logic [15:0]        bounce;
    logic signed [31:0] sax, say, sbx, sby;
  } contact_t;

  logic clk, rst, cfg_we;
  logic [15:0] cfg_data;

  cc_pair_if   #(.COORD_WIDTH(32)) req ();
  cc_result_if rsp ();

  circle_contact_and_separation dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] model_lfsr;
  logic [15:0] model_limit;

  contact_t expected_contacts[$];
  int       mismatches;
  int       idle_cycles;
  bit       rx_hold;
  bit       rx_no_idle;
  bit       tx_no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Galois step and jitter component
  function automatic logic [63:0] jitter_next(output bit neg);
    logic [31:0] j;
    model_lfsr = model_lfsr[0] ? ({1'b0, model_lfsr[15:1]} ^ 16'hB400)
                               : {1'b0, model_lfsr[15:1]};
    j = (32'(model_lfsr) * 32'd6555) >> 16;
    if (j >= 32'd3277) begin
      neg = 1'b0;
      return 64'(j - 32'd3277);
    end
    neg = 1'b1;
    return 64'(32'd3277 - j);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] unit_mag(logic [63:0] c, logic [63:0] d);
    logic [63:0] n;
    n = ((c << 15) + d / 2) / d;
    return (n > 64'd32767) ? 64'd32767 : n;
  endfunction

  function automatic logic signed [31:0] shift_of(logic [63:0] n, logic [63:0] m,
                                                   bit neg);
    logic [127:0] s;
    logic [31:0]  mag;
    s   = (128'(n) * 128'(m) + 128'd16384) >> 15;
    mag = (s > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // work out the contact for one pair, advancing the jitter LFSR as needed
  function automatic contact_t predict_contact(pair_t p);
    contact_t    r;
    logic signed [63:0] dx, dy;
    logic [63:0] ux, uy, sum, d, depth, nx, ny, rsum, total, ma, mb;
    bit          negx, negy;
    r     = '0;
    dx    = 64'(p.ax) - 64'(p.bx);
    dy    = 64'(p.ay) - 64'(p.by);
    negx  = dx < 0;
    negy  = dy < 0;
    ux    = negx ? -dx : dx;
    uy    = negy ? -dy : dy;
    rsum  = 64'(p.ra) + 64'(p.rb);
    total = 64'(p.ima) + 64'(p.imb);
    if (!(p.da || p.db)) return r;
    if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return r;
    sum = ux * ux + uy * uy;
    if (sum > rsum * rsum) return r;
    if (sum <= (64'(model_limit) << 16)) begin
      ux = jitter_next(negx);
      uy = jitter_next(negy);
      if (ux == 0 && uy == 0) begin
        ux   = 64'd3277;
        negx = 1'b0;
      end
      sum = ux * ux + uy * uy;
    end
    d     = int_sqrt(sum);
    depth = (rsum > d) ? rsum - d : 64'd0;
    nx    = unit_mag(ux, d);
    ny    = unit_mag(uy, d);
    r.touching = 1'b1;
    r.depth    = depth[30:0];
    r.nx       = negx ? -$signed(nx[15:0]) : $signed(nx[15:0]);
    r.ny       = negy ? -$signed(ny[15:0]) : $signed(ny[15:0]);
    r.bounce   = 16'((17'(p.ba) + 17'(p.bb)) >> 1);
    if (total != 0) begin
      ma = 64'((128'(depth) * 128'(p.ima) + 128'(total / 2)) / 128'(total));
      mb = 64'((128'(depth) * 128'(p.imb) + 128'(total / 2)) / 128'(total));
      r.sax = shift_of(nx, ma, negx);
      r.say = shift_of(ny, ma, negy);
      r.sbx = shift_of(nx, mb, !negx);
      r.sby = shift_of(ny, mb, !negy);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 16) << 16;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.ax = rand_coord();
    p.ay = rand_coord();
    case ($urandom_range(0, 5))
      // near-coincident centres
      0: begin
        p.bx = p.ax + $signed(32'($urandom_range(0, 4)) - 2);
        p.by = p.ay + $signed(32'($urandom_range(0, 4)) - 2);
      end
      // close pair
      1, 2, 3: begin
        p.bx = p.ax + $signed(32'($urandom_range(0, 8 << 16)) - (4 << 16));
        p.by = p.ay + $signed(32'($urandom_range(0, 8 << 16)) - (4 << 16));
      end
      default: begin
        p.bx = rand_coord();
        p.by = rand_coord();
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      p.ra = 30'($urandom);
      p.rb = 30'($urandom);
    end else begin
      p.ra = 30'($urandom_range(0, 4 << 16));
      p.rb = 30'($urandom_range(0, 4 << 16));
    end
    p.ba  = 16'($urandom);
    p.bb  = 16'($urandom);
    p.da  = ($urandom_range(0, 5) != 0);
    p.db  = 1'($urandom);
    p.ima = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    p.imb = ($urandom_range(0, 7) == 0) ? 32'd0 :
            (($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 3 << 16));
    return p;
  endfunction

  // offer one pair, hold it until the transfer
  task automatic send_pair(pair_t p);
    while (!tx_no_idle && $urandom_range(0, 99) < 35) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.pos_a_x    <= p.ax;
    req.pos_a_y    <= p.ay;
    req.pos_b_x    <= p.bx;
    req.pos_b_y    <= p.by;
    req.radius_a   <= p.ra;
    req.radius_b   <= p.rb;
    req.bounce_a   <= p.ba;
    req.bounce_b   <= p.bb;
    req.dynamic_a  <= p.da;
    req.dynamic_b  <= p.db;
    req.inv_mass_a <= p.ima;
    req.inv_mass_b <= p.imb;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_contacts.insert(expected_contacts.size(), predict_contact(p));
    @(negedge clk);
  endtask

  // wait until every result has arrived, then let the block settle
  task automatic drain();
    req.valid <= 1'b0;
    while (expected_contacts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_limit = v;
  endtask

  // receiver: random idling, one long hold-off
  always @(negedge clk) begin
    if (rst || rx_hold) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= rx_no_idle || ($urandom_range(0, 99) >= 35);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    contact_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.touching, rsp.depth, rsp.normal_x, rsp.normal_y, rsp.mean_bounce,
             rsp.shift_a_x, rsp.shift_a_y, rsp.shift_b_x, rsp.shift_b_y};
      if (expected_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = expected_contacts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on transfer-free cycles
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("circle_contact_and_separation verification failed");
        $finish;
      end
    end
  end

  // directed rows: pair and typed result where it is obvious
  pair_t    dir_pairs[$];
  contact_t dir_known[$];
  bit       dir_has[$];

  task automatic add_row(pair_t p, bit has, contact_t c);
    dir_pairs.insert(dir_pairs.size(), p);
    dir_has.insert(dir_has.size(), has);
    dir_known.insert(dir_known.size(), c);
  endtask

  initial begin
    pair_t    p;
    contact_t none, c;
    int       k;
    none        = '0;
    mismatches  = 0;
    rx_hold     = 1'b0;
    rx_no_idle  = 1'b0;
    tx_no_idle  = 1'b0;
    model_lfsr  = LFSR_SEED;
    model_limit = LIMIT_RESET;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    req.valid   = 1'b0;
    {req.pos_a_x, req.pos_a_y, req.pos_b_x, req.pos_b_y} = '0;
    {req.radius_a, req.radius_b, req.bounce_a, req.bounce_b} = '0;
    {req.dynamic_a, req.dynamic_b, req.inv_mass_a, req.inv_mass_b} = '0;
    rsp.ready   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // neither body dynamic: no contact
    p = '{ax: 0, ay: 0, bx: 0, by: 0, ra: '1, rb: '1, ba: '1, bb: '1,
          da: 0, db: 0, ima: '1, imb: '1};
    add_row(p, 1, none);
    // far apart on both extremes
    p = '{ax: 32'sh7FFFFFFF, ay: 0, bx: 32'sh80000000, by: 0, ra: '1, rb: '1,
          ba: 0, bb: 0, da: 1, db: 1, ima: 1, imb: 1};
    add_row(p, 1, none);
    p = '{ax: 0, ay: 32'sh80000000, bx: 0, by: 32'sh7FFFFFFF, ra: '1, rb: '1,
          ba: 0, bb: 0, da: 1, db: 0, ima: 0, imb: 0};
    add_row(p, 1, none);
    // just apart: dx = 3, radii 1 + 1
    p = '{ax: 3 << 16, ay: 0, bx: 0, by: 0, ra: 1 << 16, rb: 1 << 16,
          ba: 0, bb: 0, da: 1, db: 1, ima: 1 << 16, imb: 1 << 16};
    add_row(p, 1, none);
    // exact touch along +x: depth 0, normal +x
    p.ax = 2 << 16;
    c = '{touching: 1, depth: 0, nx: 16'sd32767, ny: 0, bounce: 0,
          sax: 0, say: 0, sbx: 0, sby: 0};
    add_row(p, 1, c);
    // overlap 1.0 along -y, equal masses, max restitutions
    p = '{ax: 0, ay: -(1 << 16), bx: 0, by: 0, ra: 1 << 16, rb: 1 << 16,
          ba: '1, bb: '1, da: 1, db: 1, ima: 1 << 16, imb: 1 << 16};
    c = '{touching: 1, depth: 1 << 16, nx: 0, ny: -16'sd32767, bounce: 16'hFFFF,
          sax: 0, say: -32'sd32767, sbx: 0, sby: 32'sd32767};
    add_row(p, 1, c);
    // zero total inverse mass: no shifts
    p.ima = 0;
    p.imb = 0;
    c.say = 0;
    c.sby = 0;
    add_row(p, 1, c);
    // coincident centres use jitter; extremes of positions and masses
    p = '{ax: 32'sh80000000, ay: 32'sh7FFFFFFF, bx: 32'sh80000000,
          by: 32'sh7FFFFFFF, ra: '1, rb: 0, ba: 16'h1, bb: 16'h8000,
          da: 0, db: 1, ima: '1, imb: '1};
    add_row(p, 0, none);
    p.ra = 0;
    p.rb = 1 << 16;
    p.ima = '1;
    p.imb = 0;
    add_row(p, 0, none);
    // inside the default limit, not coincident
    p = '{ax: 1, ay: 0, bx: 0, by: 0, ra: 1 << 14, rb: 1 << 14, ba: 16'h5555,
          bb: 16'hAAAA, da: 1, db: 0, ima: 0, imb: 32'h1234_5678};
    add_row(p, 0, none);
    // huge radii still apart, and an overlap with unequal masses
    p = '{ax: 32'sh7FFFFFFF, ay: 32'sh7FFFFFFF, bx: 0, by: 0, ra: '1, rb: '1,
          ba: 0, bb: '1, da: 1, db: 1, ima: '1, imb: 1};
    add_row(p, 0, none);
    p = '{ax: -(32'sd5 << 16), ay: 32'sd7 << 16, bx: 32'sd1 << 16, by: 0,
          ra: 6 << 16, rb: 5 << 16, ba: 100, bb: 200, da: 1, db: 1,
          ima: 3 << 16, imb: 1 << 15};
    add_row(p, 0, none);

    for (k = 0; k < dir_pairs.size(); k++) begin
      send_pair(dir_pairs[k]);
      if (dir_has[k] && expected_contacts[$] !== dir_known[k]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: table %p predictor %p", k, dir_known[k],
                   expected_contacts[$]);
      end
    end
    drain();

    // random phases over several degenerate limits, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_limit(16'hFFFF);
        1: write_limit(16'h0000);
        2: write_limit(16'h0040);
        3: write_limit(16'($urandom));
        default: write_limit(LIMIT_RESET);
      endcase
      tx_no_idle = (phase == 2);
      rx_no_idle = (phase == 2);
      for (int n = 0; n < 165; n++) begin
        if (phase == 1 && n == 40) begin
          fork
            begin
              rx_hold = 1'b1;
              repeat (600) @(negedge clk);
              rx_hold = 1'b0;
            end
          join_none
        end
        send_pair(rand_pair());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_contacts.size() == 0) begin
      $display("circle_contact_and_separation verification clean");
    end else begin
      $display("circle_contact_and_separation verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
